@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the RTL file that checks its own logic.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must never hold while out of reset.
`define PQ_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
		else $error("assertion failed: condition must never hold");

// Antecedent implies consequent in the same cycle.
`define PQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Antecedent implies consequent in the next cycle.
`define PQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/pq_pkg.sv @@
// ----------------------------------------------------------------------------
// pq_pkg
// Shared types and codes of the sorted priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package pq_pkg;

	// Operation codes carried on the mode input
	localparam logic PQ_PUSH = 1'b0;
	localparam logic PQ_POP  = 1'b1;

	// Result status codes
	typedef enum logic [1:0] {
		PQ_OK    = 2'd0,
		PQ_EMPTY = 2'd1,
		PQ_FULL  = 2'd2
	} pq_status_t;

	// One stored entry: data and priority
	typedef struct packed {
		logic signed [31:0] data;
		logic signed [15:0] prio;
	} pq_entry_t;

	// Sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_PUSH_RD,
		S_PUSH_CMP,
		S_POP_HEAD,
		S_POP_TAKE,
		S_POP_RD,
		S_POP_MV,
		S_DONE
	} pq_state_t;

	// Result handed from the sequencer to the output register
	typedef struct packed {
		logic               load;
		logic signed [31:0] data;
		logic signed [15:0] prio;
		pq_status_t         status;
		logic [4:0]         occupancy;
	} pq_result_t;

endpackage

`default_nettype wire

@@ rtl/pq_mem.sv @@
// ----------------------------------------------------------------------------
// pq_mem
// Entry store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pq_mem #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  wire logic              clk,
	input  wire logic              rd_en,
	input  wire logic [AW-1:0]     rd_addr,
	output      pq_pkg::pq_entry_t rd_data,
	input  wire logic              wr_en,
	input  wire logic [AW-1:0]     wr_addr,
	input  wire pq_pkg::pq_entry_t wr_data
);

	pq_pkg::pq_entry_t mem [DEPTH];
	pq_pkg::pq_entry_t rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

@@ rtl/pq_ctrl.sv @@
// ----------------------------------------------------------------------------
// pq_ctrl
// Sequencer of the queue: walks the store one entry per step with a single
// priority comparator, shifting entries back on push and forward on pop.
// ----------------------------------------------------------------------------
`default_nettype none

module pq_ctrl #(
	parameter int CAPACITY = 16,
	parameter int AW       = 4,
	parameter int CW       = 5
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// input item
	input  wire logic               in_valid,
	output      logic               in_ready,
	input  wire logic               mode,
	input  wire logic signed [31:0] in_data,
	input  wire logic signed [15:0] in_priority,
	// output register state
	input  wire logic               out_busy,
	output      pq_pkg::pq_result_t result,
	// entry store
	output      logic               rd_en,
	output      logic [AW-1:0]      rd_addr,
	input  wire pq_pkg::pq_entry_t  rd_data,
	output      logic               wr_en,
	output      logic [AW-1:0]      wr_addr,
	output      pq_pkg::pq_entry_t  wr_data
);

	pq_pkg::pq_state_t  state_q, state_d;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      pos_q;
	pq_pkg::pq_entry_t  new_q;
	pq_pkg::pq_entry_t  res_entry_q;
	pq_pkg::pq_status_t res_status_q;
	logic               accept;
	logic               is_full;
	logic               is_empty;
	logic               shift_back;
	logic               pop_last;
	logic [CW:0]        pos_plus2;

	assign accept     = in_valid && in_ready;
	assign is_full    = (count_q == CW'(CAPACITY));
	assign is_empty   = (count_q == '0);
	// shared comparator: stored entry yields to the new one only on strictly lower priority
	assign shift_back = ($signed(rd_data.prio) < $signed(new_q.prio));
	assign pos_plus2  = {1'b0, pos_q} + (CW+1)'(2);
	assign pop_last   = (pos_plus2 == {1'b0, count_q});

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pq_pkg::S_IDLE: begin
				if (accept) begin
					if (mode == pq_pkg::PQ_PUSH) begin
						state_d = is_full ? pq_pkg::S_DONE : pq_pkg::S_PUSH_RD;
					end else begin
						state_d = is_empty ? pq_pkg::S_DONE : pq_pkg::S_POP_HEAD;
					end
				end
			end
			pq_pkg::S_PUSH_RD: begin
				state_d = (pos_q == '0) ? pq_pkg::S_DONE : pq_pkg::S_PUSH_CMP;
			end
			pq_pkg::S_PUSH_CMP: begin
				state_d = shift_back ? pq_pkg::S_PUSH_RD : pq_pkg::S_DONE;
			end
			pq_pkg::S_POP_HEAD: state_d = pq_pkg::S_POP_TAKE;
			pq_pkg::S_POP_TAKE: begin
				state_d = (count_q == CW'(1)) ? pq_pkg::S_DONE : pq_pkg::S_POP_RD;
			end
			pq_pkg::S_POP_RD:   state_d = pq_pkg::S_POP_MV;
			pq_pkg::S_POP_MV: begin
				state_d = pop_last ? pq_pkg::S_DONE : pq_pkg::S_POP_RD;
			end
			pq_pkg::S_DONE: begin
				if (!out_busy) begin
					state_d = pq_pkg::S_IDLE;
				end
			end
			default: state_d = pq_pkg::S_IDLE;
		endcase
	end

	// Store access and handshake outputs
	always_comb begin
		in_ready = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = '0;
		wr_en    = 1'b0;
		wr_addr  = AW'(pos_q);
		wr_data  = new_q;
		case (state_q)
			pq_pkg::S_IDLE: in_ready = 1'b1;
			pq_pkg::S_PUSH_RD: begin
				if (pos_q == '0) begin
					wr_en = 1'b1;
				end else begin
					rd_en   = 1'b1;
					rd_addr = AW'(pos_q - CW'(1));
				end
			end
			pq_pkg::S_PUSH_CMP: begin
				wr_en   = 1'b1;
				wr_data = shift_back ? rd_data : new_q;
			end
			pq_pkg::S_POP_HEAD: rd_en = 1'b1;
			pq_pkg::S_POP_RD: begin
				rd_en   = 1'b1;
				rd_addr = AW'(pos_q + CW'(1));
			end
			pq_pkg::S_POP_MV: begin
				wr_en   = 1'b1;
				wr_data = rd_data;
			end
			default: ;
		endcase
	end

	// Result toward the output register
	always_comb begin
		result.load      = (state_q == pq_pkg::S_DONE) && !out_busy;
		result.data      = res_entry_q.data;
		result.prio      = res_entry_q.prio;
		result.status    = res_status_q;
		result.occupancy = 5'(count_q);
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pq_pkg::S_IDLE;
			count_q <= '0;
			pos_q   <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				pq_pkg::S_IDLE: begin
					pos_q <= (accept && mode == pq_pkg::PQ_PUSH) ? count_q : '0;
				end
				pq_pkg::S_PUSH_RD: begin
					if (pos_q == '0) begin
						count_q <= count_q + CW'(1);
					end
				end
				pq_pkg::S_PUSH_CMP: begin
					if (shift_back) begin
						pos_q <= pos_q - CW'(1);
					end else begin
						count_q <= count_q + CW'(1);
					end
				end
				pq_pkg::S_POP_TAKE: begin
					if (count_q == CW'(1)) begin
						count_q <= '0;
					end
				end
				pq_pkg::S_POP_MV: begin
					pos_q <= pos_q + CW'(1);
					if (pop_last) begin
						count_q <= count_q - CW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// Hold the new entry and the result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			new_q.data   <= in_data;
			new_q.prio   <= in_priority;
			res_entry_q  <= '0;
			if (mode == pq_pkg::PQ_PUSH) begin
				res_status_q <= is_full ? pq_pkg::PQ_FULL : pq_pkg::PQ_OK;
			end else begin
				res_status_q <= is_empty ? pq_pkg::PQ_EMPTY : pq_pkg::PQ_OK;
			end
		end else if (state_q == pq_pkg::S_POP_TAKE) begin
			res_entry_q <= rd_data;
		end
	end

endmodule

`default_nettype wire

@@ rtl/sorted_shift_priority_queue.sv @@
// Push reads entries from the tail toward the head, moving each lower-priority entry
// back, then writes the new entry; pop reads the head, then moves each remaining entry
// forward. Push to a full queue and pop from an empty queue go straight to the result.
// One item at a time; each store step is a registered read, then a write (after a
// compare on push). The next item is accepted in the cycle after its result loads,
// later if the output is stalled. Reset empties the queue; store content is unset.
// ----------------------------------------------------------------------------
// sorted_shift_priority_queue
// Fixed-capacity priority queue kept in descending priority order, with
// arrival order among equal priorities and an output register per result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sorted_shift_priority_queue #(
	parameter int CAPACITY = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output      logic               in_ready,
	input  wire logic               mode,
	input  wire logic signed [31:0] in_data,
	input  wire logic signed [15:0] in_priority,
	output      logic               out_valid,
	input  wire logic               out_ready,
	output      logic signed [31:0] out_data,
	output      logic signed [15:0] out_priority,
	output      logic [1:0]         status,
	output      logic [4:0]         occupancy
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	pq_pkg::pq_result_t result;
	pq_pkg::pq_entry_t  rd_data;
	pq_pkg::pq_entry_t  wr_data;
	logic               rd_en;
	logic               wr_en;
	logic [AW-1:0]      rd_addr;
	logic [AW-1:0]      wr_addr;
	logic               out_valid_q;
	logic signed [31:0] out_data_q;
	logic signed [15:0] out_prio_q;
	logic [1:0]         status_q;
	logic [4:0]         occupancy_q;
	logic               out_busy;
	logic               out_is_empty;
	logic               out_is_full;
	logic               out_payload_zero;

	assign out_busy = out_valid_q && !out_ready;

	pq_ctrl #(
		.CAPACITY (CAPACITY),
		.AW       (AW),
		.CW       (CW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.mode        (mode),
		.in_data     (in_data),
		.in_priority (in_priority),
		.out_busy    (out_busy),
		.result      (result),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.rd_data     (rd_data),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data)
	);

	pq_mem #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	// Output valid: set on a new result, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (result.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (result.load) begin
			out_data_q  <= result.data;
			out_prio_q  <= result.prio;
			status_q    <= result.status;
			occupancy_q <= result.occupancy;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_data     = out_data_q;
	assign out_priority = out_prio_q;
	assign status       = status_q;
	assign occupancy    = occupancy_q;

	// Rejected operations carry an all-zero entry
	assign out_is_empty     = out_valid && (status == pq_pkg::PQ_EMPTY);
	assign out_is_full      = out_valid && (status == pq_pkg::PQ_FULL);
	assign out_payload_zero = (out_data == 32'sd0) && (out_priority == 16'sd0);

	// Checks
	`PQ_ASSERT_NEVER(a_load_over_pending, clk, arst_n, result.load && out_valid_q && !out_ready)
	`PQ_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)
	`PQ_ASSERT_IMPL(a_empty_zero, clk, arst_n, out_is_empty, out_payload_zero && occupancy == 5'd0)
	`PQ_ASSERT_IMPL(a_full_zero, clk, arst_n, out_is_full, out_payload_zero)
	`PQ_ASSERT_NEVER(a_mem_collide, clk, arst_n, rd_en && wr_en)

endmodule

`default_nettype wire

@@ tb/sorted_shift_priority_queue_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_shift_priority_queue_tb
// Drives pushes and pops into the priority queue with random gaps on both
// sides, tracks the queue contents in a local sorted array and checks each
// returned item field by field, including full and empty rejections.
// ----------------------------------------------------------------------------

module sorted_shift_priority_queue_tb;

	localparam int CAPACITY = 16;

	// One queue operation as driven on the input channel
	typedef struct packed {
		logic               op;
		logic signed [31:0] data;
		logic signed [15:0] prio;
	} queue_op_t;

	// One result item as seen on the output channel
	typedef struct packed {
		logic signed [31:0] data;
		logic signed [15:0] prio;
		pq_pkg::pq_status_t status;
		logic [4:0]         occupancy;
	} queue_result_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic               mode;
	logic signed [31:0] in_data;
	logic signed [15:0] in_priority;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] out_data;
	logic signed [15:0] out_priority;
	logic [1:0]         status;
	logic [4:0]         occupancy;

	queue_op_t         pending_items[$];
	queue_result_t     expected_results[$];
	pq_pkg::pq_entry_t model_store[CAPACITY];
	int                model_count;
	int                accepted_count;
	int                send_wait;
	int                stall_left;
	int                quiet_left[2];
	int                err_count;

	sorted_shift_priority_queue #(
		.CAPACITY(CAPACITY)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.in_data(in_data),
		.in_priority(in_priority),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.out_priority(out_priority),
		.status(status),
		.occupancy(occupancy)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Apply one operation to the local copy of the queue and return its result
	function automatic queue_result_t predict_queue_op(input logic op,
			input logic signed [31:0] data, input logic signed [15:0] prio);
		queue_result_t res;
		int pos;
		res = '0;
		res.status = pq_pkg::PQ_OK;
		if (op == pq_pkg::PQ_PUSH) begin
			if (model_count >= CAPACITY) begin
				res.status = pq_pkg::PQ_FULL;
			end else begin
				// shift lower priorities back, insert behind equal ones
				pos = model_count;
				while (pos > 0 && model_store[pos - 1].prio < prio) begin
					model_store[pos] = model_store[pos - 1];
					pos = pos - 1;
				end
				model_store[pos].data = data;
				model_store[pos].prio = prio;
				model_count = model_count + 1;
			end
		end else begin
			if (model_count == 0) begin
				res.status = pq_pkg::PQ_EMPTY;
			end else begin
				res.data = model_store[0].data;
				res.prio = model_store[0].prio;
				for (int k = 0; k + 1 < model_count; k++)
					model_store[k] = model_store[k + 1];
				model_count = model_count - 1;
			end
		end
		res.occupancy = 5'(model_count);
		return res;
	endfunction

	// Pick an idle length: mostly none or short, a few long, some quiet runs
	function automatic int pick_gap(input int side);
		int r;
		if (quiet_left[side] > 0) begin
			quiet_left[side] = quiet_left[side] - 1;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			quiet_left[side] = $urandom_range(20, 60);
			return 0;
		end
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Favor a few close priorities so ties are common
	function automatic logic signed [15:0] rand_priority();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return 16'($signed($urandom_range(0, 3)) - 1);
		if (r < 50) begin
			case ($urandom_range(0, 3))
				0: return 16'sh8000;
				1: return 16'sh7fff;
				2: return 16'sh0000;
				default: return 16'shffff;
			endcase
		end
		return 16'($urandom);
	endfunction

	function automatic void add_item(input logic op, input logic signed [31:0] data,
			input logic signed [15:0] prio);
		queue_op_t item;
		item.op = op;
		item.data = data;
		item.prio = prio;
		pending_items.push_back(item);
	endfunction

	// Driver: present pending items, predict each one as it is accepted
	always @(posedge clk or negedge arst_n) begin
		queue_op_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			mode <= pq_pkg::PQ_PUSH;
			in_data <= '0;
			in_priority <= '0;
			send_wait <= 0;
			accepted_count <= 0;
		end else if (!in_valid || in_ready) begin
			if (in_valid) begin
				expected_results.push_back(predict_queue_op(mode, in_data, in_priority));
				accepted_count <= accepted_count + 1;
			end
			if (send_wait > 0) begin
				send_wait <= send_wait - 1;
				in_valid <= 1'b0;
			end else if (pending_items.size() > 0) begin
				nxt = pending_items.pop_front();
				mode <= nxt.op;
				in_data <= nxt.data;
				in_priority <= nxt.prio;
				in_valid <= 1'b1;
				send_wait <= pick_gap(0);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: check each returned item against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		queue_result_t exp_res;
		int g;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected item: data %h prio %h status %0d occ %0d",
						$time, out_data, out_priority, status, occupancy);
					err_count = err_count + 1;
				end else begin
					exp_res = expected_results.pop_front();
					if (out_data !== exp_res.data) begin
						$display("%0t: out_data expected %h actual %h",
							$time, exp_res.data, out_data);
						err_count = err_count + 1;
					end
					if (out_priority !== exp_res.prio) begin
						$display("%0t: out_priority expected %h actual %h",
							$time, exp_res.prio, out_priority);
						err_count = err_count + 1;
					end
					if (status !== exp_res.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, exp_res.status, status);
						err_count = err_count + 1;
					end
					if (occupancy !== exp_res.occupancy) begin
						$display("%0t: occupancy expected %0d actual %0d",
							$time, exp_res.occupancy, occupancy);
						err_count = err_count + 1;
					end
				end
				g = pick_gap(1);
				stall_left <= g;
				out_ready <= (g == 0);
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_ready <= (stall_left == 1);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Stimulus and end of run
	initial begin
		int total;
		int round_len;
		int push_pct;
		int random_items;
		err_count = 0;
		model_count = 0;
		quiet_left[0] = 0;
		quiet_left[1] = 0;
		arst_n = 1'b0;

		// directed: empty pop, field extremes, ties, then drain past empty
		add_item(pq_pkg::PQ_POP, 32'sh1234_5678, 16'sh7fff);
		add_item(pq_pkg::PQ_PUSH, 32'sh7fff_ffff, 16'sh7fff);
		add_item(pq_pkg::PQ_PUSH, 32'sh8000_0000, 16'sh8000);
		add_item(pq_pkg::PQ_PUSH, 32'sh0000_0000, 16'sh0000);
		add_item(pq_pkg::PQ_PUSH, 32'shffff_ffff, 16'sh0000);
		add_item(pq_pkg::PQ_PUSH, 32'sh0000_0005, 16'sh0000);
		add_item(pq_pkg::PQ_PUSH, 32'sh5555_5555, 16'sh5555);
		add_item(pq_pkg::PQ_PUSH, 32'shaaaa_aaaa, 16'shaaaa);
		add_item(pq_pkg::PQ_PUSH, 32'sh0000_0001, 16'shffff);
		add_item(pq_pkg::PQ_PUSH, 32'sh0000_0002, 16'sh0001);
		for (int i = 0; i < 10; i++)
			add_item(pq_pkg::PQ_POP, 32'($urandom), 16'($urandom));

		// fill well past capacity so full pushes get rejected
		for (int i = 0; i < 20; i++)
			add_item(pq_pkg::PQ_PUSH, 32'($urandom), rand_priority());

		// rounds that lean toward filling, draining or a mix
		random_items = 0;
		while (random_items < 680) begin
			round_len = $urandom_range(20, 60);
			case ($urandom_range(0, 2))
				0: push_pct = 85;
				1: push_pct = 15;
				default: push_pct = 50;
			endcase
			for (int i = 0; i < round_len; i++) begin
				if ($urandom_range(0, 99) < push_pct)
					add_item(pq_pkg::PQ_PUSH, 32'($urandom), rand_priority());
				else
					add_item(pq_pkg::PQ_POP, 32'($urandom), 16'($urandom));
			end
			random_items = random_items + round_len;
		end

		// drain to empty and beyond
		for (int i = 0; i < 20; i++)
			add_item(pq_pkg::PQ_POP, 32'($urandom), 16'($urandom));
		total = pending_items.size();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (accepted_count < total)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		// allow a stray late item to show up
		repeat (80) @(posedge clk);

		if (err_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#4_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
